>>> rtl/ipv4_source_lpm_filter_macros.svh
// assertion helpers shared by the filter modules
// both expect clk and rst_n in the scope of the module that uses them
`ifndef IPV4_SOURCE_LPM_FILTER_MACROS_SVH
`define IPV4_SOURCE_LPM_FILTER_MACROS_SVH

// same-cycle implication
`define LPMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lpmf_pkg.sv
package lpmf_pkg;

  localparam int unsigned NUM_RULES_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_ABORT = 2'd2;

  localparam logic [5:0]  COUNT_MAX      = 6'd63;
  localparam logic [5:0]  ETH_HDR_LEN    = 6'd14;
  localparam logic [5:0]  IPV4_MIN_LEN   = 6'd34;
  localparam logic [5:0]  PREFIX_LEN_MAX = 6'd32;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_VERDICT,
    CMD_LOOKUP
  } cmd_kind_t;

  // work handed from the front to the back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  verdict;
    logic [3:0]  slot;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [31:0] value;
    logic        enable;
  } cmd_t;

  typedef struct packed {
    logic [63:0] count_value;
    logic [31:0] hit_rule;
    logic        hit;
    logic [1:0]  verdict;
  } res_t;

endpackage

>>> rtl/lpmf_front.sv
module lpmf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic [3:0]       in_slot,
  input  logic [31:0]      in_prefix_addr,
  input  logic [5:0]       in_prefix_len,
  input  logic [31:0]      in_rule_number,
  input  logic             in_rule_enable,
  input  logic             q_full,
  output logic             push,
  output lpmf_pkg::cmd_t   push_cmd
);

  typedef enum logic [1:0] {
    MODE_BYTE,
    MODE_WRITE,
    MODE_READ,
    MODE_NONE
  } mode_t;

  logic [5:0]  byte_count_r, byte_count_nxt;
  logic [15:0] ether_type_r, ether_type_nxt;
  logic [31:0] source_addr_r, source_addr_nxt;
  logic [5:0]  count_inc;
  logic        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    ether_type_nxt  = ether_type_r;
    source_addr_nxt = source_addr_r;
    count_inc       = (byte_count_r < lpmf_pkg::COUNT_MAX) ? byte_count_r + 6'd1 : byte_count_r;
    push            = 1'b0;
    push_cmd        = '0;
    if (acc) begin
      unique case (mode_t'(in_mode))
        MODE_BYTE: begin
          if (byte_count_r == 6'd12 || byte_count_r == 6'd13) begin
            ether_type_nxt = {ether_type_r[7:0], in_byte};
          end else if (byte_count_r >= 6'd26 && byte_count_r <= 6'd29) begin
            source_addr_nxt = {source_addr_r[23:0], in_byte};
          end
          byte_count_nxt = count_inc;
          if (in_last) begin
            push          = 1'b1;
            push_cmd.kind = lpmf_pkg::CMD_VERDICT;
            push_cmd.addr = source_addr_nxt;
            // header checks settle everything but the table lookup
            if (count_inc < lpmf_pkg::ETH_HDR_LEN) begin
              push_cmd.verdict = lpmf_pkg::VERDICT_ABORT;
            end else if (ether_type_nxt != lpmf_pkg::ETHERTYPE_IPV4) begin
              push_cmd.verdict = lpmf_pkg::VERDICT_PASS;
            end else if (count_inc < lpmf_pkg::IPV4_MIN_LEN) begin
              push_cmd.verdict = lpmf_pkg::VERDICT_ABORT;
            end else begin
              push_cmd.kind = lpmf_pkg::CMD_LOOKUP;
            end
            byte_count_nxt  = '0;
            ether_type_nxt  = '0;
            source_addr_nxt = '0;
          end
        end
        MODE_WRITE: begin
          push            = 1'b1;
          push_cmd.kind   = lpmf_pkg::CMD_WRITE;
          push_cmd.slot   = in_slot;
          push_cmd.addr   = in_prefix_addr;
          push_cmd.len    = (in_prefix_len > lpmf_pkg::PREFIX_LEN_MAX) ?
                            lpmf_pkg::PREFIX_LEN_MAX : in_prefix_len;
          push_cmd.value  = in_rule_number;
          push_cmd.enable = in_rule_enable;
        end
        MODE_READ: begin
          push          = 1'b1;
          push_cmd.kind = lpmf_pkg::CMD_READ;
          push_cmd.slot = in_slot;
        end
        MODE_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      ether_type_r  <= '0;
      source_addr_r <= '0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      ether_type_r  <= ether_type_nxt;
      source_addr_r <= source_addr_nxt;
    end
  end

endmodule

>>> rtl/lpmf_queue.sv
`include "ipv4_source_lpm_filter_macros.svh"

module lpmf_queue #(
  parameter int unsigned DEPTH = lpmf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpmf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lpmf_pkg::cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpmf_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `LPMF_ASSERT_NOW(a_no_overflow, push, !full, "queue written while full")
  `LPMF_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")
  `LPMF_ASSERT_NEXT(a_fill_step, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "fill count lost a write")

endmodule

>>> rtl/lpmf_back.sv
`include "ipv4_source_lpm_filter_macros.svh"

module lpmf_back #(
  parameter int unsigned NUM_RULES = lpmf_pkg::NUM_RULES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lpmf_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output lpmf_pkg::res_t res
);

  localparam int unsigned IDX_W  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int unsigned SCAN_W = $clog2(NUM_RULES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOOKUP_END,
    ST_COUNT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [31:0] value;
  } rule_entry_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len >= lpmf_pkg::PREFIX_LEN_MAX) begin
      m = '1;
    end else if (len != '0) begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

  rule_entry_t       rule_mem [NUM_RULES];
  logic [63:0]       cnt_mem  [NUM_RULES];

  state_t            st_r, st_nxt;
  logic [SCAN_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [31:0]       src_r, src_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [5:0]        best_len_r, best_len_nxt;
  logic [31:0]       best_value_r, best_value_nxt;
  logic [IDX_W-1:0]  cnt_idx_r, cnt_idx_nxt;
  logic              cnt_ok_r, cnt_ok_nxt;
  logic [NUM_RULES-1:0] rule_valid_r, rule_valid_nxt;
  logic [NUM_RULES-1:0] cnt_valid_r, cnt_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  lpmf_pkg::res_t    res_r, res_nxt;

  rule_entry_t       rule_rd_r;
  logic [63:0]       cnt_rd_r;

  logic              rule_we, rule_re;
  logic [IDX_W-1:0]  rule_waddr, rule_raddr;
  rule_entry_t       rule_wdata;
  logic              cnt_we, cnt_re;
  logic [IDX_W-1:0]  cnt_waddr, cnt_raddr;
  logic [63:0]       cnt_wdata;

  logic              out_free;
  logic              emit;
  logic              slot_ok;
  logic              value_ok;
  logic              rule_match;

  assign out_free  = !out_valid_r || res_ready;
  assign res_valid = out_valid_r;
  assign res       = res_r;
  assign slot_ok   = 32'(q_head.slot) < 32'(NUM_RULES);
  assign value_ok  = best_value_r < 32'(NUM_RULES);
  assign rule_match = rule_valid_r[chk_idx_r]
                   && (((src_r ^ rule_rd_r.prefix) & prefix_mask(rule_rd_r.len)) == '0)
                   && (!best_vld_r || rule_rd_r.len > best_len_r);

  always_comb begin
    st_nxt         = st_r;
    scan_cnt_nxt   = scan_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    src_nxt        = src_r;
    best_vld_nxt   = best_vld_r;
    best_len_nxt   = best_len_r;
    best_value_nxt = best_value_r;
    cnt_idx_nxt    = cnt_idx_r;
    cnt_ok_nxt     = cnt_ok_r;
    rule_valid_nxt = rule_valid_r;
    cnt_valid_nxt  = cnt_valid_r;
    out_valid_nxt  = out_valid_r && !res_ready;
    res_nxt        = res_r;
    emit           = 1'b0;
    q_pop          = 1'b0;
    rule_we        = 1'b0;
    rule_waddr     = IDX_W'(q_head.slot);
    rule_wdata     = '{prefix: q_head.addr, len: q_head.len, value: q_head.value};
    rule_re        = 1'b0;
    rule_raddr     = scan_cnt_r[IDX_W-1:0];
    cnt_we         = 1'b0;
    cnt_waddr      = cnt_idx_r;
    cnt_wdata      = (cnt_valid_r[cnt_idx_r] ? cnt_rd_r : 64'd0) + 64'd1;
    cnt_re         = 1'b0;
    cnt_raddr      = IDX_W'(q_head.slot);

    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            lpmf_pkg::CMD_WRITE: begin
              q_pop = 1'b1;
              if (slot_ok) begin
                rule_we = 1'b1;
                rule_valid_nxt[IDX_W'(q_head.slot)] = q_head.enable;
              end
            end
            lpmf_pkg::CMD_READ: begin
              q_pop       = 1'b1;
              cnt_re      = slot_ok;
              cnt_ok_nxt  = slot_ok;
              cnt_idx_nxt = IDX_W'(q_head.slot);
              st_nxt      = ST_READ;
            end
            lpmf_pkg::CMD_VERDICT: begin
              if (out_free) begin
                q_pop   = 1'b1;
                emit    = 1'b1;
                res_nxt = '{count_value: 64'd0, hit_rule: 32'd0, hit: 1'b0,
                            verdict: q_head.verdict};
              end
            end
            lpmf_pkg::CMD_LOOKUP: begin
              q_pop        = 1'b1;
              src_nxt      = q_head.addr;
              scan_cnt_nxt = '0;
              best_vld_nxt = 1'b0;
              st_nxt       = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue one rule read per cycle, check the one read in the previous cycle
        if (scan_cnt_r < SCAN_W'(NUM_RULES)) begin
          rule_re      = 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else begin
          st_nxt = ST_LOOKUP_END;
        end
        if (chk_vld_r && rule_match) begin
          best_vld_nxt   = 1'b1;
          best_len_nxt   = rule_rd_r.len;
          best_value_nxt = rule_rd_r.value;
        end
      end
      ST_LOOKUP_END: begin
        if (best_vld_r && value_ok) begin
          cnt_re      = 1'b1;
          cnt_raddr   = IDX_W'(best_value_r);
          cnt_idx_nxt = IDX_W'(best_value_r);
          st_nxt      = ST_COUNT;
        end else if (out_free) begin
          emit    = 1'b1;
          res_nxt = '{count_value: 64'd0,
                      hit_rule: best_vld_r ? best_value_r : 32'd0,
                      hit: best_vld_r,
                      verdict: best_vld_r ? lpmf_pkg::VERDICT_DROP : lpmf_pkg::VERDICT_PASS};
          st_nxt  = ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (out_free) begin
          cnt_we                   = 1'b1;
          cnt_valid_nxt[cnt_idx_r] = 1'b1;
          emit                     = 1'b1;
          res_nxt = '{count_value: 64'd0, hit_rule: best_value_r, hit: 1'b1,
                      verdict: lpmf_pkg::VERDICT_DROP};
          st_nxt  = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          emit    = 1'b1;
          res_nxt = '{count_value: (cnt_ok_r && cnt_valid_r[cnt_idx_r]) ? cnt_rd_r : 64'd0,
                      hit_rule: 32'd0, hit: 1'b0, verdict: lpmf_pkg::VERDICT_PASS};
          st_nxt  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      scan_cnt_r   <= '0;
      chk_vld_r    <= 1'b0;
      chk_idx_r    <= '0;
      best_vld_r   <= 1'b0;
      cnt_ok_r     <= 1'b0;
      cnt_idx_r    <= '0;
      rule_valid_r <= '0;
      cnt_valid_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      chk_vld_r    <= chk_vld_nxt;
      chk_idx_r    <= chk_idx_nxt;
      best_vld_r   <= best_vld_nxt;
      cnt_ok_r     <= cnt_ok_nxt;
      cnt_idx_r    <= cnt_idx_nxt;
      rule_valid_r <= rule_valid_nxt;
      cnt_valid_r  <= cnt_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    src_r        <= src_nxt;
    best_len_r   <= best_len_nxt;
    best_value_r <= best_value_nxt;
    res_r        <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[rule_waddr] <= rule_wdata;
    end
    if (rule_re) begin
      rule_rd_r <= rule_mem[rule_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_r <= cnt_mem[cnt_raddr];
    end
  end

  `LPMF_ASSERT_NOW(a_scan_bound, st_r == ST_SCAN, scan_cnt_r <= SCAN_W'(NUM_RULES), "scan ran past the table")
  `LPMF_ASSERT_NEXT(a_count_marked, cnt_we, cnt_valid_r[$past(cnt_waddr)], "counter written but not marked")
  `LPMF_ASSERT_NEXT(a_hit_is_drop, emit && res_nxt.hit, out_valid_r && res_r.verdict == lpmf_pkg::VERDICT_DROP, "hit without drop verdict")

endmodule

>>> rtl/ipv4_source_lpm_filter.sv
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    tdata: frame byte and rule fields, tuser: mode, tlast
// out_     out  out_tvalid/tready   tdata: verdict, hit, hit_rule, count_value
//
// frame bytes are taken one per cycle while the queue has room
// a table lookup passes the back end states ST_SCAN (one rule read per cycle) and ST_LOOKUP_END,
// then ST_COUNT when a hit bumps a counter; a counter read passes ST_READ
// a queue of QUEUE_DEPTH commands sits between front and back; front stalls only when full
// rst_n clears parser, queue, rule valid bits and counter valid bits at once, no sweep
// the result register holds while out_tready is low; the back end keeps working until its next result is due
module ipv4_source_lpm_filter #(
  parameter int unsigned NUM_RULES   = lpmf_pkg::NUM_RULES_DEF,
  parameter int unsigned QUEUE_DEPTH = lpmf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // packet_byte, slot, prefix_addr, prefix_len, rule_number, rule_enable, zero pad
  input  logic [lpmf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic [1:0]                       in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // verdict, hit, hit_rule, count_value, zero pad
  output logic [lpmf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  lpmf_pkg::cmd_t push_cmd;
  lpmf_pkg::cmd_t head_cmd;
  lpmf_pkg::res_t res;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  lpmf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_mode        (in_tuser),
    .in_byte        (in_tdata[7:0]),
    .in_last        (in_tlast),
    .in_slot        (in_tdata[11:8]),
    .in_prefix_addr (in_tdata[43:12]),
    .in_prefix_len  (in_tdata[49:44]),
    .in_rule_number (in_tdata[81:50]),
    .in_rule_enable (in_tdata[82]),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  lpmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  lpmf_back #(
    .NUM_RULES (NUM_RULES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_cmd),
    .q_pop     (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {5'd0, res};

endmodule
